// ===== sv/hpw_pkg.sv =====
// Shared types and constants for the histogram percentile window block.
`timescale 1ns / 1ps

package hpw_pkg;

   localparam int DATA_W          = 32;
   localparam int FRAC_W          = 16;
   localparam int BIN_FIELD_W     = 9;
   localparam int PADDR_W         = 4;
   localparam int BINS_DEF        = 512;
   localparam int COUNT_WIDTH_DEF = 32;

   localparam logic [FRAC_W-1:0] LOW_FRAC_RESET  = 16'd3277;
   localparam logic [FRAC_W-1:0] HIGH_FRAC_RESET = 16'd64881;

   typedef enum logic [1:0] {
      REG_RANGE_MIN  = 2'd0,
      REG_RANGE_MAX  = 2'd1,
      REG_LOW_FRAC   = 2'd2,
      REG_HIGH_FRAC  = 2'd3
   } reg_idx_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_PREP,
      ST_CLASS,
      ST_DIV,
      ST_READ,
      ST_WRITE,
      ST_THR_LO,
      ST_THR_HI,
      ST_SCAN,
      ST_SCAN_END,
      ST_LVL_LO,
      ST_LVL_LO_WAIT,
      ST_LVL_HI,
      ST_LVL_HI_WAIT,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] sample;
      logic                     is_last;
   } req_type;

   typedef struct packed {
      logic signed [DATA_W-1:0]  window_low;
      logic signed [DATA_W-1:0]  window_high;
      logic [BIN_FIELD_W-1:0]    low_bin;
      logic [BIN_FIELD_W-1:0]    high_bin;
      logic                      range_degenerate;
   } rsp_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] range_min;
      logic signed [DATA_W-1:0] range_max;
      logic [FRAC_W-1:0]        low_fraction;
      logic [FRAC_W-1:0]        high_fraction;
   } cfg_type;

   typedef struct packed {
      logic rd_inc;
      logic rd_scan;
      logic wipe;
      logic scan_init;
   } hist_cmd_type;

endpackage

// ===== sv/hpw_csr.sv =====
// Configuration register file behind the APB-style port.
`timescale 1ns / 1ps

module hpw_csr (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         psel,
   input  logic                         penable,
   input  logic                         pwrite,
   input  logic [hpw_pkg::PADDR_W-1:0]  paddr,
   input  logic [hpw_pkg::DATA_W-1:0]   pwdata,
   output logic [hpw_pkg::DATA_W-1:0]   prdata,
   output logic                         pready,
   output hpw_pkg::cfg_type             cfg
);
   import hpw_pkg::*;

   cfg_type     cfg_ff;
   reg_idx_type idx;

   assign idx    = reg_idx_type'(paddr[PADDR_W-1:2]);
   assign pready = 1'b1;
   assign cfg    = cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.range_min     <= '0;
         cfg_ff.range_max     <= '0;
         cfg_ff.low_fraction  <= LOW_FRAC_RESET;
         cfg_ff.high_fraction <= HIGH_FRAC_RESET;
      end else if (psel && penable && pwrite) begin
         unique case (idx)
            REG_RANGE_MIN: cfg_ff.range_min     <= pwdata;
            REG_RANGE_MAX: cfg_ff.range_max     <= pwdata;
            REG_LOW_FRAC:  cfg_ff.low_fraction  <= pwdata[FRAC_W-1:0];
            REG_HIGH_FRAC: cfg_ff.high_fraction <= pwdata[FRAC_W-1:0];
         endcase
      end
   end

   always_comb begin
      unique case (idx)
         REG_RANGE_MIN: prdata = cfg_ff.range_min;
         REG_RANGE_MAX: prdata = cfg_ff.range_max;
         REG_LOW_FRAC:  prdata = DATA_W'(cfg_ff.low_fraction);
         REG_HIGH_FRAC: prdata = DATA_W'(cfg_ff.high_fraction);
      endcase
   end

endmodule

// ===== sv/hpw_div.sv =====
// Bit-serial restoring divider, one quotient bit per cycle, 32-bit quotient.
`timescale 1ns / 1ps

module hpw_div #(
   parameter int PW = hpw_pkg::DATA_W + 10
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [PW-1:0]               dividend,
   input  logic [hpw_pkg::DATA_W-1:0]  divisor,
   output logic                        done,
   output logic [hpw_pkg::DATA_W-1:0]  quotient
);
   import hpw_pkg::*;

   localparam int CW = $clog2(DATA_W);

   logic [DATA_W-1:0] rem_ff, rem_in;
   logic [DATA_W-1:0] low_ff;
   logic [DATA_W-1:0] dvs_ff;
   logic [DATA_W-1:0] quot_ff;
   logic [CW-1:0]     cnt_ff;
   logic              run_ff;
   logic              done_ff;
   logic [DATA_W:0]   trial;
   logic [DATA_W:0]   diff;
   logic              fits;

   // high part of the dividend is below the divisor, so 32 steps suffice
   assign trial  = {rem_ff, low_ff[DATA_W-1]};
   assign diff   = trial - {1'b0, dvs_ff};
   assign fits   = trial >= {1'b0, dvs_ff};
   assign rem_in = fits ? diff[DATA_W-1:0] : trial[DATA_W-1:0];

   assign done     = done_ff;
   assign quotient = quot_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            run_ff <= 1'b1;
            cnt_ff <= '0;
         end else if (run_ff) begin
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == CW'(DATA_W - 1)) begin
               run_ff  <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= DATA_W'(dividend[PW-1:DATA_W]);
         low_ff <= dividend[DATA_W-1:0];
         dvs_ff <= divisor;
      end else if (run_ff) begin
         rem_ff  <= rem_in;
         low_ff  <= {low_ff[DATA_W-2:0], 1'b0};
         quot_ff <= {quot_ff[DATA_W-2:0], fits};
      end
   end

endmodule

// ===== sv/hpw_hist.sv =====
// Histogram bin memory with saturating update, total count and percentile scan.
`timescale 1ns / 1ps

module hpw_hist #(
   parameter int BINS        = hpw_pkg::BINS_DEF,
   parameter int COUNT_WIDTH = hpw_pkg::COUNT_WIDTH_DEF
) (
   input  logic                                                     clock,
   input  logic                                                     reset,
   input  hpw_pkg::hist_cmd_type                                    cmd,
   input  logic [$clog2(BINS)-1:0]                                  addr,
   input  logic [COUNT_WIDTH+$clog2(BINS)+hpw_pkg::FRAC_W-1:0]      thr_lo,
   input  logic [COUNT_WIDTH+$clog2(BINS)+hpw_pkg::FRAC_W-1:0]      thr_hi,
   output logic [COUNT_WIDTH+$clog2(BINS)-1:0]                      total,
   output logic [$clog2(BINS)-1:0]                                  lo_bin,
   output logic [$clog2(BINS)-1:0]                                  hi_bin
);
   import hpw_pkg::*;

   localparam int AW = $clog2(BINS);
   localparam int TW = COUNT_WIDTH + AW;

   logic [COUNT_WIDTH-1:0] mem [BINS];
   logic [COUNT_WIDTH-1:0] rd_ff;
   logic [AW-1:0]          addr_ff;
   logic                   inc_ff;
   logic                   scan_ff;
   logic [TW-1:0]          total_ff;
   logic [TW-1:0]          cum_ff, cum_in;
   logic                   lo_found_ff, hi_found_ff;
   logic [AW-1:0]          lo_bin_ff, hi_bin_ff;
   logic                   sat;
   logic                   above_lo, above_hi;
   logic                   we;
   logic [AW-1:0]          wa;
   logic [COUNT_WIDTH-1:0] wd;

   assign sat      = &rd_ff;
   assign cum_in   = cum_ff + TW'(rd_ff);
   assign above_lo = {cum_in, {FRAC_W{1'b0}}} > thr_lo;
   assign above_hi = {cum_in, {FRAC_W{1'b0}}} > thr_hi;

   assign total  = total_ff;
   assign lo_bin = lo_bin_ff;
   assign hi_bin = hi_bin_ff;

   // scan reads clear each bin behind them
   always_comb begin
      we = 1'b0;
      wa = addr_ff;
      wd = '0;
      priority if (cmd.wipe) begin
         we = 1'b1;
         wa = addr;
      end else if (inc_ff && !sat) begin
         we = 1'b1;
         wd = rd_ff + 1'b1;
      end else if (scan_ff) begin
         we = 1'b1;
      end else begin
         we = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rd_inc || cmd.rd_scan) rd_ff <= mem[addr];
      if (we) mem[wa] <= wd;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         inc_ff      <= 1'b0;
         scan_ff     <= 1'b0;
         total_ff    <= '0;
         lo_found_ff <= 1'b0;
         hi_found_ff <= 1'b0;
      end else begin
         inc_ff  <= cmd.rd_inc;
         scan_ff <= cmd.rd_scan;
         if (cmd.scan_init) begin
            total_ff    <= '0;
            lo_found_ff <= 1'b0;
            hi_found_ff <= 1'b0;
         end else begin
            if (inc_ff && !sat) total_ff <= total_ff + 1'b1;
            if (scan_ff && above_lo) lo_found_ff <= 1'b1;
            if (scan_ff && above_hi) hi_found_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      addr_ff <= addr;
      if (cmd.scan_init) begin
         cum_ff    <= '0;
         lo_bin_ff <= '0;
         hi_bin_ff <= '0;
      end else if (scan_ff) begin
         cum_ff <= cum_in;
         if (!lo_found_ff && above_lo) lo_bin_ff <= addr_ff;
         if (!hi_found_ff && above_hi) hi_bin_ff <= addr_ff;
      end
   end

endmodule

// ===== sv/histogram_percentile_window_top.sv =====
// Histogram percentile window level: sequencer, binning datapath and result register.
//
//   channel   ports                                   direction  handshake
//   req       start, busy, req_beat                   in         start & !busy
//   rsp       rsp_valid, rsp_beat                     out        one-cycle strobe
//   csr       psel, penable, pwrite, paddr, pwdata,   in/out     APB write, pready high
//             prdata, pready
//
// A sample inside the range gets its bin index from the 32-step bit-serial divider;
// a sample outside the range skips the divider, and one under a degenerate range
// also skips the bin update. The last sample adds one memory read per bin
// for the scan, then two serial divides for the levels (none under a degenerate range).
// After reset a clearing pass zeroes every bin with busy high.
// The receiver cannot stall: each result is on rsp_beat for the single rsp_valid cycle.
`timescale 1ns / 1ps

module histogram_percentile_window_top #(
   parameter int BINS        = hpw_pkg::BINS_DEF,
   parameter int COUNT_WIDTH = hpw_pkg::COUNT_WIDTH_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  hpw_pkg::req_type             req_beat,
   output logic                         rsp_valid,
   output hpw_pkg::rsp_type             rsp_beat,
   input  logic                         psel,
   input  logic                         penable,
   input  logic                         pwrite,
   input  logic [hpw_pkg::PADDR_W-1:0]  paddr,
   input  logic [hpw_pkg::DATA_W-1:0]   pwdata,
   output logic [hpw_pkg::DATA_W-1:0]   prdata,
   output logic                         pready
);
   import hpw_pkg::*;

   localparam int AW   = $clog2(BINS);
   localparam int BW   = $clog2(BINS + 1);
   localparam int TW   = COUNT_WIDTH + AW;
   localparam int CMPW = TW + FRAC_W;
   localparam int PW   = DATA_W + BW;
   localparam logic [AW-1:0] LAST_BIN = AW'(BINS - 1);

   cfg_type           cfg;
   state_type         state_ff, state_in;
   req_type           item_ff;
   logic [DATA_W:0]   d_ff;
   logic [DATA_W:0]   span_full;
   logic [DATA_W-1:0] span_ff;
   logic              degen_ff;
   logic              in_span;
   logic [AW-1:0]     bin_ff;
   logic [AW-1:0]     cnt_ff;
   logic [CMPW-1:0]   thr_lo_ff, thr_hi_ff;
   rsp_type           rsp_ff;

   logic              div_start, div_done;
   logic [PW-1:0]     div_dividend;
   logic [DATA_W-1:0] div_divisor, div_quot;
   logic [AW-1:0]     lvl_bin;
   logic [DATA_W-1:0] level;

   hist_cmd_type      hist_cmd;
   logic [AW-1:0]     hist_addr;
   logic [TW-1:0]     hist_total;
   logic [AW-1:0]     hist_lo_bin, hist_hi_bin;

   hpw_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   hpw_div #(.PW(PW)) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .done     (div_done),
      .quotient (div_quot)
   );

   hpw_hist #(.BINS(BINS), .COUNT_WIDTH(COUNT_WIDTH)) u_hist (
      .clock  (clock),
      .reset  (reset),
      .cmd    (hist_cmd),
      .addr   (hist_addr),
      .thr_lo (thr_lo_ff),
      .thr_hi (thr_hi_ff),
      .total  (hist_total),
      .lo_bin (hist_lo_bin),
      .hi_bin (hist_hi_bin)
   );

   assign span_full = {cfg.range_max[DATA_W-1], cfg.range_max}
                    - {cfg.range_min[DATA_W-1], cfg.range_min};
   assign in_span   = !d_ff[DATA_W] && (d_ff[DATA_W-1:0] < span_ff);
   assign level     = cfg.range_min + div_quot;
   assign rsp_beat  = rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_CLEAR;
      else       state_ff <= state_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else if (state_ff == ST_CLEAR || state_ff == ST_SCAN) begin
         cnt_ff <= (cnt_ff == LAST_BIN) ? '0 : cnt_ff + 1'b1;
      end else if (state_ff == ST_THR_HI) begin
         cnt_ff <= '0;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR:       if (cnt_ff == LAST_BIN) state_in = ST_IDLE;
         ST_IDLE:        if (start) state_in = ST_PREP;
         ST_PREP:        state_in = ST_CLASS;
         ST_CLASS: begin
            priority if (degen_ff) state_in = item_ff.is_last ? ST_THR_LO : ST_IDLE;
            else if (in_span)      state_in = ST_DIV;
            else                   state_in = ST_READ;
         end
         ST_DIV:         if (div_done) state_in = ST_READ;
         ST_READ:        state_in = ST_WRITE;
         ST_WRITE:       state_in = item_ff.is_last ? ST_THR_LO : ST_IDLE;
         ST_THR_LO:      state_in = ST_THR_HI;
         ST_THR_HI:      state_in = ST_SCAN;
         ST_SCAN:        if (cnt_ff == LAST_BIN) state_in = ST_SCAN_END;
         ST_SCAN_END:    state_in = degen_ff ? ST_EMIT : ST_LVL_LO;
         ST_LVL_LO:      state_in = ST_LVL_LO_WAIT;
         ST_LVL_LO_WAIT: if (div_done) state_in = ST_LVL_HI;
         ST_LVL_HI:      state_in = ST_LVL_HI_WAIT;
         ST_LVL_HI_WAIT: if (div_done) state_in = ST_EMIT;
         ST_EMIT:        state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      busy               = state_ff != ST_IDLE;
      rsp_valid          = state_ff == ST_EMIT;
      div_start          = (state_ff == ST_CLASS && !degen_ff && in_span)
                         || state_ff == ST_LVL_LO || state_ff == ST_LVL_HI;
      lvl_bin            = (state_ff == ST_LVL_HI) ? hist_hi_bin : hist_lo_bin;
      if (state_ff == ST_CLASS) begin
         div_dividend = PW'(d_ff[DATA_W-1:0]) * PW'(BINS);
         div_divisor  = span_ff;
      end else begin
         div_dividend = PW'(lvl_bin) * PW'(span_ff);
         div_divisor  = DATA_W'(BINS);
      end
      hist_cmd.rd_inc    = state_ff == ST_READ;
      hist_cmd.rd_scan   = state_ff == ST_SCAN;
      hist_cmd.wipe      = state_ff == ST_CLEAR;
      hist_cmd.scan_init = state_ff == ST_THR_HI;
      hist_addr          = (state_ff == ST_READ) ? bin_ff : cnt_ff;
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_IDLE && start) item_ff <= req_beat;
      if (state_ff == ST_PREP) begin
         d_ff     <= {item_ff.sample[DATA_W-1], item_ff.sample}
                   - {cfg.range_min[DATA_W-1], cfg.range_min};
         span_ff  <= span_full[DATA_W-1:0];
         degen_ff <= !($signed(cfg.range_max) > $signed(cfg.range_min));
      end
      if (state_ff == ST_CLASS) begin
         if (d_ff[DATA_W])  bin_ff <= '0;
         else if (!in_span) bin_ff <= LAST_BIN;
      end
      if (state_ff == ST_DIV && div_done) bin_ff <= div_quot[AW-1:0];
      if (state_ff == ST_THR_LO) thr_lo_ff <= CMPW'(hist_total) * CMPW'(cfg.low_fraction);
      if (state_ff == ST_THR_HI) thr_hi_ff <= CMPW'(hist_total) * CMPW'(cfg.high_fraction);
      if (state_ff == ST_SCAN_END) begin
         rsp_ff <= {{(2*DATA_W + 2*BIN_FIELD_W){1'b0}}, degen_ff};
      end
      if (state_ff == ST_LVL_LO_WAIT && div_done) begin
         rsp_ff.window_low <= level;
         rsp_ff.low_bin    <= BIN_FIELD_W'(hist_lo_bin);
      end
      if (state_ff == ST_LVL_HI_WAIT && div_done) begin
         rsp_ff.window_high <= level;
         rsp_ff.high_bin    <= BIN_FIELD_W'(hist_hi_bin);
      end
   end

endmodule
